@@ sv/pngs_pkg.sv @@
// Shared types, constants and functions of the PNG stored-deflate encoder.
// Used by png_stored_deflate_encoder_core and its testbench; depends on nothing.

package pngs_pkg;

	localparam int CFG_W = 14;
	localparam int BYTE_W = 8;
	localparam int STEP_W = 6;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	localparam logic [STEP_W-1:0] RESULT_CAP = 6'd43;
	localparam logic [STEP_W-1:0] HDR_LAST = 6'd42;
	localparam logic [STEP_W-1:0] BLK_LAST = 6'd4;
	localparam logic [STEP_W-1:0] TRL_LAST = 6'd19;

	typedef enum logic [0:0] {
		OP_FRAME = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b0_0000_0001,
		ST_MUL  = 9'b0_0000_0010,
		ST_DIV  = 9'b0_0000_0100,
		ST_LEN  = 9'b0_0000_1000,
		ST_HDR  = 9'b0_0001_0000,
		ST_ERR  = 9'b0_0010_0000,
		ST_RAW  = 9'b0_0100_0000,
		ST_BLK  = 9'b0_1000_0000,
		ST_TRL  = 9'b1_0000_0000
	} state_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] be_byte(input logic [31:0] x, input logic [1:0] sel);
		logic [7:0] r;
		case (sel)
			2'd0: r = x[31:24];
			2'd1: r = x[23:16];
			2'd2: r = x[15:8];
			default: r = x[7:0];
		endcase
		return r;
	endfunction

endpackage

@@ sv/pngs_blkdiv.sv @@
// Block counter: the ceiling of the raw byte count over BLOCK_MAX by a reciprocal multiplication.
// Done is start registered through run_q and then done_q; uses nothing from the package.

module pngs_blkdiv #(
	parameter int RAW_W = 28,
	parameter int BLOCK_MAX = 65535
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RAW_W-1:0] dividend,
	output logic             done,
	output logic [RAW_W-1:0] blocks
);

	localparam int Y_W = RAW_W + 1;
	localparam int K_W = $clog2(BLOCK_MAX);
	localparam int SH = Y_W + K_W;
	localparam int M_W = Y_W + 1;
	localparam int P_W = Y_W + M_W;
	localparam logic [63:0] RECIP64 =
		((64'd1 << SH) + 64'(BLOCK_MAX) - 64'd1) / 64'(BLOCK_MAX);
	localparam logic [M_W-1:0] RECIP = M_W'(RECIP64);

	logic [Y_W-1:0]   y_q;
	logic [RAW_W-1:0] blk_q;
	logic             run_q;
	logic             done_q;
	logic [P_W-1:0]   prod;

	assign prod = P_W'(y_q) * P_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q <= start;
			done_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q <= Y_W'(dividend) + Y_W'(BLOCK_MAX - 1);
		end
		if (run_q) begin
			blk_q <= RAW_W'(prod >> SH);
		end
	end

	assign done = done_q;
	assign blocks = blk_q;

endmodule

@@ sv/png_stored_deflate_encoder_core.sv @@
// Streaming PNG encoder for 8-bit RGB pixels: top level with the byte sequencer.
// Depends on pngs_pkg and instantiates the block counter pngs_blkdiv.
// The core emits one file byte per clock cycle when the output side does not stall. Every
// transfer is accepted in the idle state. A frame-start transfer then goes through the
// multiply, block-count and length states before its 43 header bytes. A pixel transfer emits
// three or four data bytes, plus five at each stored-block boundary, plus twenty on the last
// pixel; the sequencer also passes a state without output at each block boundary, and another
// when the frame's byte count runs out before the pixel's blue byte.
// A pixel outside an open frame gives a single error byte. The input stalls while an item is
// in work; configuration writes are always taken and should be made between frames.

module png_stored_deflate_encoder_core #(
	parameter int MAX_SIDE = 8192,
	parameter int BLOCK_MAX = 65535
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic                      last_of_run,
	output logic                      file_end,
	output logic                      seq_error,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [0:0]                cfg_index,
	input  logic [pngs_pkg::CFG_W-1:0] cfg_data
);

	import pngs_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int RAW_W = $clog2(MAX_SIDE * (3 * MAX_SIDE + 1) + 1);
	localparam int TW_W = SIDE_W + 2;
	localparam int PROD_W = SIDE_W + TW_W;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (32'(v) > 32'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = SIDE_W'(v);
		end
		return r;
	endfunction

	state_t state_q;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic              frame_open_q;
	logic [31:0]       crc_q;
	logic [15:0]       adler_lo_q;
	logic [15:0]       adler_hi_q;
	logic [SIDE_W-1:0] col_q;
	logic [15:0]       blk_left_q;
	logic [RAW_W-1:0]  raw_left_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] cnt_q;
	logic [1:0]        slot_q;

	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic [7:0]        blue_q;
	logic [SIDE_W-1:0] wc_q;
	logic [SIDE_W-1:0] hc_q;
	logic [RAW_W-1:0]  raw_q;
	logic [31:0]       len_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       end_q;
	logic       err_q;

	logic [TW_W-1:0]   tw;
	logic [PROD_W-1:0] prod;
	logic              div_done;
	logic [RAW_W-1:0]  blocks;

	logic        emit;
	logic [7:0]  byte_d;
	logic        incl;
	logic        crst;
	logic        nat_last;
	logic        nat_end;
	logic        err_d;
	logic        drop;
	logic        adv;
	logic        pix_state;

	logic [7:0]  hdr_b;
	logic [7:0]  raw_b;
	logic [7:0]  blk_b;
	logic [7:0]  trl_b;
	logic [31:0] raw_ext;
	logic        blk_final;
	logic [15:0] blk_n;
	logic [31:0] crc_fin;
	logic [31:0] w32;
	logic [31:0] h32;
	logic [1:0]  sel29;
	logic [1:0]  sel33;

	logic [16:0] lo_sum;
	logic [15:0] lo_new;
	logic [16:0] hi_sum;
	logic [15:0] hi_new;

	logic [SIDE_W-1:0] wc_now;
	logic [SIDE_W:0]   col_inc;

	assign tw = TW_W'({wc_q, 1'b0}) + TW_W'(wc_q) + TW_W'(1);
	assign prod = PROD_W'(hc_q) * PROD_W'(tw);

	pngs_blkdiv #(
		.RAW_W(RAW_W),
		.BLOCK_MAX(BLOCK_MAX)
	) u_blkdiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_MUL),
		.dividend(RAW_W'(prod)),
		.done(div_done),
		.blocks(blocks)
	);

	assign crc_fin = crc_q ^ ALL_ONES;
	assign w32 = 32'(wc_q);
	assign h32 = 32'(hc_q);
	assign sel29 = 2'(step_q - 6'd29);
	assign sel33 = 2'(step_q - 6'd33);

	always_comb begin
		hdr_b = 8'h00;
		case (step_q)
			6'd0: hdr_b = 8'h89;
			6'd1: hdr_b = 8'h50;
			6'd2: hdr_b = 8'h4E;
			6'd3: hdr_b = 8'h47;
			6'd4: hdr_b = 8'h0D;
			6'd5: hdr_b = 8'h0A;
			6'd6: hdr_b = 8'h1A;
			6'd7: hdr_b = 8'h0A;
			6'd11: hdr_b = 8'd13;
			6'd12: hdr_b = 8'h49;
			6'd13: hdr_b = 8'h48;
			6'd14: hdr_b = 8'h44;
			6'd15: hdr_b = 8'h52;
			6'd24: hdr_b = 8'd8;
			6'd25: hdr_b = 8'd2;
			6'd37: hdr_b = 8'h49;
			6'd38: hdr_b = 8'h44;
			6'd39: hdr_b = 8'h41;
			6'd40: hdr_b = 8'h54;
			6'd41: hdr_b = 8'h78;
			6'd42: hdr_b = 8'h01;
			default: begin
				if (step_q inside {[6'd16:6'd19]}) begin
					hdr_b = be_byte(w32, step_q[1:0]);
				end else if (step_q inside {[6'd20:6'd23]}) begin
					hdr_b = be_byte(h32, step_q[1:0]);
				end else if (step_q inside {[6'd29:6'd32]}) begin
					hdr_b = be_byte(crc_fin, sel29);
				end else if (step_q inside {[6'd33:6'd36]}) begin
					hdr_b = be_byte(len_q, sel33);
				end
			end
		endcase
	end

	always_comb begin
		case (slot_q)
			2'd0: raw_b = 8'h00;
			2'd1: raw_b = red_q;
			2'd2: raw_b = green_q;
			default: raw_b = blue_q;
		endcase
	end

	assign raw_ext = 32'(raw_left_q);
	assign blk_final = raw_ext <= 32'(BLOCK_MAX);
	assign blk_n = blk_final ? 16'(raw_left_q) : 16'(BLOCK_MAX);

	always_comb begin
		case (step_q)
			6'd0: blk_b = {7'd0, blk_final};
			6'd1: blk_b = blk_n[7:0];
			6'd2: blk_b = blk_n[15:8];
			6'd3: blk_b = ~blk_n[7:0];
			default: blk_b = ~blk_n[15:8];
		endcase
	end

	always_comb begin
		trl_b = 8'h00;
		if (step_q inside {[6'd0:6'd3]}) begin
			trl_b = be_byte({adler_hi_q, adler_lo_q}, step_q[1:0]);
		end else if (step_q inside {[6'd4:6'd7]}) begin
			trl_b = be_byte(crc_fin, step_q[1:0]);
		end else if (step_q inside {[6'd16:6'd19]}) begin
			trl_b = be_byte(crc_fin, step_q[1:0]);
		end else begin
			case (step_q)
				6'd12: trl_b = 8'h49;
				6'd13: trl_b = 8'h45;
				6'd14: trl_b = 8'h4E;
				6'd15: trl_b = 8'h44;
				default: trl_b = 8'h00;
			endcase
		end
	end

	always_comb begin
		emit = 1'b0;
		byte_d = 8'h00;
		incl = 1'b0;
		crst = 1'b0;
		nat_last = 1'b0;
		nat_end = 1'b0;
		err_d = 1'b0;
		case (state_q)
			ST_HDR: begin
				emit = 1'b1;
				byte_d = hdr_b;
				incl = step_q inside {[6'd12:6'd28], [6'd37:6'd42]};
				crst = (step_q == 6'd12) || (step_q == 6'd37);
				nat_last = step_q == HDR_LAST;
			end
			ST_ERR: begin
				emit = 1'b1;
				err_d = 1'b1;
				nat_last = 1'b1;
			end
			ST_RAW: begin
				if (raw_left_q != '0 && blk_left_q != 16'd0) begin
					emit = 1'b1;
					byte_d = raw_b;
					incl = 1'b1;
					nat_last = (slot_q == 2'd3) && (raw_left_q != RAW_W'(1));
				end
			end
			ST_BLK: begin
				emit = 1'b1;
				byte_d = blk_b;
				incl = 1'b1;
			end
			ST_TRL: begin
				emit = 1'b1;
				byte_d = trl_b;
				incl = step_q inside {[6'd0:6'd3], [6'd12:6'd15]};
				crst = step_q == 6'd12;
				nat_last = step_q == TRL_LAST;
				nat_end = step_q == TRL_LAST;
			end
			default: begin
			end
		endcase
	end

	assign pix_state = (state_q == ST_RAW) || (state_q == ST_BLK) || (state_q == ST_TRL);
	assign drop = cnt_q >= RESULT_CAP;
	assign adv = emit && (drop || !out_valid_q || !out_stall);

	assign lo_sum = {1'b0, adler_lo_q} + {9'd0, raw_b};
	assign lo_new = 16'(lo_sum >= ADLER_MOD ? lo_sum - ADLER_MOD : lo_sum);
	assign hi_sum = {1'b0, adler_hi_q} + {1'b0, lo_new};
	assign hi_new = 16'(hi_sum >= ADLER_MOD ? hi_sum - ADLER_MOD : hi_sum);

	assign wc_now = clamp_side(width_q);
	assign col_inc = {1'b0, col_q} + (SIDE_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			frame_open_q <= 1'b0;
			crc_q <= ALL_ONES;
			adler_lo_q <= 16'd1;
			adler_hi_q <= 16'd0;
			col_q <= '0;
			blk_left_q <= 16'd0;
			raw_left_q <= '0;
			step_q <= '0;
			cnt_q <= '0;
			slot_q <= 2'd0;
		end else begin
			if (adv) begin
				cnt_q <= cnt_q + 1'b1;
				if (incl) begin
					crc_q <= crc_byte(crst ? ALL_ONES : crc_q, byte_d);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						step_q <= '0;
						if (op == OP_FRAME) begin
							state_q <= ST_MUL;
						end else if (!frame_open_q) begin
							state_q <= ST_ERR;
						end else begin
							slot_q <= (col_q == '0) ? 2'd0 : 2'd1;
							state_q <= ST_RAW;
						end
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: state_q <= ST_HDR;
				ST_HDR: begin
					if (adv) begin
						step_q <= step_q + 1'b1;
						if (step_q == HDR_LAST) begin
							frame_open_q <= 1'b1;
							adler_lo_q <= 16'd1;
							adler_hi_q <= 16'd0;
							col_q <= '0;
							blk_left_q <= 16'd0;
							raw_left_q <= raw_q;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RAW: begin
					if (raw_left_q == '0) begin
						step_q <= '0;
						state_q <= ST_TRL;
					end else if (blk_left_q == 16'd0) begin
						step_q <= '0;
						state_q <= ST_BLK;
					end else if (adv) begin
						adler_lo_q <= lo_new;
						adler_hi_q <= hi_new;
						blk_left_q <= blk_left_q - 1'b1;
						raw_left_q <= raw_left_q - 1'b1;
						if (slot_q == 2'd3) begin
							col_q <= (col_inc >= {1'b0, wc_now}) ? '0 : SIDE_W'(col_inc);
							step_q <= '0;
							state_q <= (raw_left_q == RAW_W'(1)) ? ST_TRL : ST_IDLE;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end
				ST_BLK: begin
					if (adv) begin
						step_q <= step_q + 1'b1;
						if (step_q == BLK_LAST) begin
							blk_left_q <= blk_n;
							state_q <= ST_RAW;
						end
					end
				end
				ST_TRL: begin
					if (adv) begin
						step_q <= step_q + 1'b1;
						if (step_q == TRL_LAST) begin
							frame_open_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			red_q <= red;
			green_q <= green;
			blue_q <= blue;
			wc_q <= clamp_side(width_q);
			hc_q <= clamp_side(height_q);
		end
		if (state_q == ST_MUL) begin
			raw_q <= RAW_W'(prod);
		end
		if (state_q == ST_LEN) begin
			len_q <= 32'(raw_q) + (32'(blocks) << 2) + 32'(blocks) + 32'd6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && !drop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !drop) begin
			out_byte_q <= byte_d;
			last_q <= nat_last || (cnt_q == RESULT_CAP - 1'b1);
			end_q <= nat_end || (pix_state && cnt_q == RESULT_CAP - 1'b1);
			err_q <= err_d;
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last_of_run = last_q;
	assign file_end = end_q;
	assign seq_error = err_q;

`ifndef SYNTHESIS
	a_err_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seq_error |-> last_of_run && out_byte == 8'h00)
		else $error("error transfer is not a single zero byte");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && file_end |-> last_of_run)
		else $error("file end byte does not close its run");

	a_err_route: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_PIXEL && !frame_open_q |=> state_q == ST_ERR)
		else $error("pixel outside a frame was not rejected");

	a_trl_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRL |-> frame_open_q && raw_left_q == '0)
		else $error("trailer started with raw bytes still pending");
`endif

endmodule

@@ tb/sv/tb_png_stored_deflate_encoder_core.sv @@
// Self-checking testbench for png_stored_deflate_encoder_core.
// Depends on pngs_pkg; models the PNG byte stream and compares every byte and flag.

module tb_png_stored_deflate_encoder_core;
	import pngs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fend;
		logic       err;
	} file_byte_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic last_of_run;
	logic file_end;
	logic seq_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	png_stored_deflate_encoder_core dut (.*);

	always #1 clk = ~clk;

	// Encoder state mirrored on the checker side.
	logic [13:0] width_reg = 14'd1;
	logic [13:0] height_reg = 14'd1;
	logic        in_frame = 1'b0;
	logic [31:0] run_crc = ALL_ONES;
	logic [31:0] sum_low = 32'd1;
	logic [31:0] sum_high = 32'd0;
	logic [31:0] col_pos = 0;
	logic [31:0] row_pos = 0;
	logic [31:0] block_left = 0;
	logic [31:0] raw_left = 0;
	int          bytes_this_item;

	file_byte_t  file_bytes_due[$];
	pixel_item_t pixels_pending[$];
	int          items_queued = 0;
	int          items_taken = 0;
	int          cfg_writes_taken = 0;
	bit          item_took = 0;
	bit          idle_enable = 1;
	int          in_idle_left = 0;
	int          out_stall_left = 0;
	int          fails = 0;
	longint      cycles = 0;

	function automatic logic [31:0] clamp_side(logic [13:0] v);
		if (v == 0) return 1;
		if (v > 8192) return 8192;
		return 32'(v);
	endfunction

	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ b;
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic emit(logic [7:0] b);
		if (bytes_this_item < 43) begin
			file_bytes_due.insert(file_bytes_due.size(), file_byte_t'{b, 1'b0, 1'b0, 1'b0});
		end
		bytes_this_item++;
	endtask

	task automatic emit_crc(logic [7:0] b);
		run_crc = crc_step(run_crc, b);
		emit(b);
	endtask

	task automatic emit_word(logic [31:0] x, bit with_crc);
		for (int i = 3; i >= 0; i--) begin
			if (with_crc) emit_crc(x[8*i +: 8]);
			else emit(x[8*i +: 8]);
		end
	endtask

	task automatic emit_raw(logic [7:0] b);
		logic [31:0] n;
		if (raw_left == 0) return;
		if (block_left == 0) begin
			n = raw_left < 65535 ? raw_left : 65535;
			emit_crc(raw_left <= 65535 ? 8'd1 : 8'd0);
			emit_crc(n[7:0]);
			emit_crc(n[15:8]);
			emit_crc(~n[7:0]);
			emit_crc(~n[15:8]);
			block_left = n;
		end
		emit_crc(b);
		sum_low = (sum_low + b) % 65521;
		sum_high = (sum_high + sum_low) % 65521;
		block_left--;
		raw_left--;
	endtask

	task automatic predict_frame_start();
		logic [31:0] w, h, raw, blocks;
		w = clamp_side(width_reg);
		h = clamp_side(height_reg);
		raw = h * (3 * w + 1);
		blocks = raw / 65535 + ((raw % 65535) != 0);
		emit(8'h89); emit("P"); emit("N"); emit("G");
		emit(8'h0D); emit(8'h0A); emit(8'h1A); emit(8'h0A);
		emit_word(32'd13, 0);
		run_crc = ALL_ONES;
		emit_crc("I"); emit_crc("H"); emit_crc("D"); emit_crc("R");
		emit_word(w, 1);
		emit_word(h, 1);
		emit_crc(8'd8); emit_crc(8'd2); emit_crc(8'd0); emit_crc(8'd0); emit_crc(8'd0);
		emit_word(run_crc ^ ALL_ONES, 0);
		emit_word(2 + raw + 5 * blocks + 4, 0);
		run_crc = ALL_ONES;
		emit_crc("I"); emit_crc("D"); emit_crc("A"); emit_crc("T");
		emit_crc(8'h78); emit_crc(8'h01);
		sum_low = 1;
		sum_high = 0;
		col_pos = 0;
		row_pos = 0;
		block_left = 0;
		raw_left = raw;
		in_frame = 1;
	endtask

	task automatic predict_trailer();
		emit_word({sum_high[15:0], sum_low[15:0]}, 1);
		emit_word(run_crc ^ ALL_ONES, 0);
		emit_word(32'd0, 0);
		run_crc = ALL_ONES;
		emit_crc("I"); emit_crc("E"); emit_crc("N"); emit_crc("D");
		emit_word(run_crc ^ ALL_ONES, 0);
		file_bytes_due[$].fend = 1'b1;
		in_frame = 0;
	endtask

	task automatic predict_item(pixel_item_t it);
		int start;
		start = file_bytes_due.size();
		bytes_this_item = 0;
		if (it.op == OP_FRAME) begin
			predict_frame_start();
		end else if (!in_frame) begin
			file_bytes_due.insert(file_bytes_due.size(), file_byte_t'{8'd0, 1'b0, 1'b0, 1'b1});
		end else begin
			if (col_pos == 0) emit_raw(8'd0);
			emit_raw(it.red);
			emit_raw(it.green);
			emit_raw(it.blue);
			col_pos++;
			if (col_pos >= clamp_side(width_reg)) begin
				col_pos = 0;
				row_pos = (row_pos + 1) & 32'h3FFF;
			end
			if (raw_left == 0) predict_trailer();
		end
		if (file_bytes_due.size() > start) file_bytes_due[$].last = 1'b1;
	endtask

	// Input and configuration transfers feed the predictor; output transfers are checked.
	always @(posedge clk) begin
		file_byte_t want;
		cycles++;
		if (cycles > 3000000) begin
			$display("tb: failure");
			$finish;
		end else begin
			if (in_valid && !in_stall) begin
				predict_item('{op_t'(op), red, green, blue});
				items_taken++;
				item_took = 1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				cfg_writes_taken++;
			end
			if (out_valid && !out_stall) begin
				if (file_bytes_due.size() == 0) begin
					$error("unexpected output transfer, out_byte %0h", out_byte);
					fails++;
				end else begin
					want = file_bytes_due.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte expected %0h actual %0h", want.data, out_byte);
						fails++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run expected %0b actual %0b", want.last, last_of_run);
						fails++;
					end
					if (file_end !== want.fend) begin
						$error("file_end expected %0b actual %0b", want.fend, file_end);
						fails++;
					end
					if (seq_error !== want.err) begin
						$error("seq_error expected %0b actual %0b", want.err, seq_error);
						fails++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		pixel_item_t it;
		logic next_valid;
		next_valid = in_valid && !item_took;
		item_took = 0;
		if (!next_valid) begin
			if (in_idle_left > 0) begin
				in_idle_left--;
			end else if (pixels_pending.size() > 0) begin
				if (idle_enable && $urandom_range(0, 3) == 0) begin
					in_idle_left = $urandom_range(0, 9);
				end else begin
					it = pixels_pending.pop_front();
					op <= it.op;
					red <= it.red;
					green <= it.green;
					blue <= it.blue;
					next_valid = 1;
				end
			end
		end
		in_valid <= next_valid;
		if (out_stall_left > 0) begin
			out_stall_left--;
			out_stall <= 1'b1;
		end else if (idle_enable && $urandom_range(0, 4) == 0) begin
			out_stall_left = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send(op_t o, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixels_pending.insert(pixels_pending.size(), pixel_item_t'{o, r, g, b});
		items_queued++;
	endtask

	task automatic send_pixels(int n);
		repeat (n) send(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (items_taken != items_queued || file_bytes_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
		int seen;
		seen = cfg_writes_taken;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(negedge clk);
		while (cfg_writes_taken == seen);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int w, h, n;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send(OP_FRAME, 8'hA5, 8'h5A, 8'hFF);
		send(OP_PIXEL, 8'h00, 8'h00, 8'h00);
		send(OP_PIXEL, 8'h12, 8'h34, 8'h56);
		send(OP_FRAME, 8'h00, 8'h00, 8'h00);
		send(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		wait_drained();
		write_reg(REG_WIDTH, 14'd0);
		write_reg(REG_HEIGHT, 14'd0);
		send(OP_FRAME, 8'h00, 8'h00, 8'h00);
		send(OP_PIXEL, 8'h80, 8'h01, 8'h7F);
		wait_drained();
		write_reg(REG_WIDTH, 14'h3FFF);
		write_reg(REG_HEIGHT, 14'h3FFF);
		send(OP_FRAME, 8'h00, 8'h00, 8'h00);
		send_pixels(3);
		send(OP_FRAME, 8'h00, 8'h00, 8'h00);
		send_pixels(2);
		wait_drained();
		write_reg(REG_WIDTH, 14'd2);
		write_reg(REG_HEIGHT, 14'd2);
		send(OP_FRAME, 8'h00, 8'h00, 8'h00);
		send_pixels(2);
		wait_drained();
		write_reg(REG_WIDTH, 14'd3);
		send_pixels(6);
		wait_drained();

		n = items_queued;
		while (n < 250) begin
			if (n > 170) idle_enable = 0;
			w = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6);
			h = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4);
			write_reg(REG_WIDTH, CFG_W'(w));
			write_reg(REG_HEIGHT, CFG_W'(h));
			send(OP_FRAME, 8'($urandom), 8'($urandom), 8'($urandom));
			case ($urandom_range(0, 5))
				0: send_pixels($urandom_range(0, w * h));
				1: send_pixels(w * h + (w * h == 0) + $urandom_range(1, 2));
				default: send_pixels(w == 0 || h == 0 ? 1 : w * h);
			endcase
			n = items_queued;
			wait_drained();
		end

		repeat (50) @(negedge clk);
		if (fails == 0 && file_bytes_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
